>>> rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, inactive during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/esc_pkg.sv
`timescale 1ns / 1ps

package esc_pkg;

    // port widths
    localparam int UNIX_W = 38;
    localparam int ZONE_W = 17;

    // zone offset after reset, +3 hours
    localparam logic signed [ZONE_W-1:0] ZONE_RESET = 17'sd10800;

    // seconds from 1601-01-01 to 1970-01-01
    localparam logic [38:0] EPOCH_BIAS = 39'd11644473600;

    // a day is 2^7 * 675 seconds
    localparam int unsigned DAY_SHIFT = 7;
    localparam int unsigned DAY_DIV   = 675;
    localparam int unsigned SEC_DAY   = 86400;
    localparam int unsigned SEC_HOUR  = 3600;
    localparam int unsigned SEC_MIN   = 60;

    // period lengths in days
    localparam int unsigned DAYS_400Y = 146097;
    localparam int unsigned DAYS_100Y = 36524;
    localparam int unsigned DAYS_4Y   = 1461;
    localparam int unsigned DAYS_1Y   = 365;
    localparam int unsigned WEEK_DAYS = 7;

    // clamp limits of the period counts
    localparam int unsigned CENT_MAX = 3;
    localparam int unsigned QUAD_MAX = 24;
    localparam int unsigned ANN_MAX  = 3;

    localparam int unsigned YEAR_BASE = 1601;
    localparam int unsigned YEAR_TM   = 1900;

    // reciprocals floor(2^k / d), k = dividend width, so the estimate is exact or one low
    localparam longint unsigned RCP_SEC  = (64'd1 << 32) / 64'(DAY_DIV);
    localparam longint unsigned RCP_400Y = (64'd1 << 23) / 64'(DAYS_400Y);
    localparam longint unsigned RCP_WEEK = (64'd1 << 24) / 64'(WEEK_DAYS);
    localparam longint unsigned RCP_HOUR = (64'd1 << 17) / 64'(SEC_HOUR);
    localparam longint unsigned RCP_MIN  = (64'd1 << 12) / 64'(SEC_MIN);
    localparam longint unsigned RCP_4Y   = (64'd1 << 16) / 64'(DAYS_4Y);

    // cumulative days before each month, common and leap year
    localparam logic [8:0] CUM_DAYS [2][13] = '{
        '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
          9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
        '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
          9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
    };

    typedef struct packed {
        logic       hit;
        logic [3:0] mon;
    } month_sel_t;

    // first month whose cumulative end exceeds the day of year
    function automatic month_sel_t month_find(input logic [8:0] yday, input logic leap);
        month_sel_t sel;
        sel.hit = 1'b0;
        sel.mon = 4'd11;
        for (int m = 12; m >= 1; m--)
        begin
            if (yday < CUM_DAYS[leap][m])
            begin
                sel.hit = 1'b1;
                sel.mon = 4'(m - 1);
            end
        end
        return sel;
    endfunction

endpackage

>>> rtl/epoch_seconds_to_calendar.sv
`timescale 1ns / 1ps
// epoch_seconds_to_calendar: unix seconds to broken-down gregorian local time
//
// input channel: in_valid / in_stall with unix_seconds; a transfer happens on a
//   rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall with the eight calendar fields; one result
//   per input item, in order
// config channel: cfg_valid / cfg_ready with cfg_data, the signed zone offset in
//   seconds; cfg_ready is always high, write only while the pipeline is empty
// path: an input transfer loads the stage A register, and the item then moves
//   through the B to N registers in order; the N register drives the outputs
// throughput: one item per cycle unless stalled; fourteen register stages,
//   each about one constant-reciprocal multiply or one narrow subtract and compare
// stall: out_stall holding a valid result freezes every stage at once, in_stall
//   follows it in the same cycle; nothing is dropped or repeated
// reset: all stage valid bits clear, zone offset returns to +10800 s (+3 hours)
`include "assert_macros.svh"

module epoch_seconds_to_calendar (
    input  logic                              clk,
    input  logic                              rst_n,
    // item input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [esc_pkg::UNIX_W-1:0]        unix_seconds,
    // result output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [5:0]                        second_of_minute,
    output logic [5:0]                        minute_of_hour,
    output logic [4:0]                        hour_of_day,
    output logic [4:0]                        day_of_month,
    output logic [3:0]                        month_index,
    output logic [12:0]                       years_since_1900,
    output logic [2:0]                        day_of_week,
    output logic [8:0]                        day_of_year,
    // zone offset register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic signed [esc_pkg::ZONE_W-1:0] cfg_data
);
    import esc_pkg::*;

    localparam int NUM_STAGES = 14;
    localparam int STG_D      = 3;
    localparam int STG_G      = 6;
    localparam int STG_OUT    = NUM_STAGES - 1;

    // stage payloads
    typedef struct packed {
        logic [38:0] s;
    } a_t;

    typedef struct packed {
        logic [22:0] q0;
        logic [10:0] t_lo;
        logic [6:0]  lo7;
    } b_t;

    typedef struct packed {
        logic [22:0] q0;
        logic [10:0] r0;
        logic [6:0]  lo7;
    } c_t;

    typedef struct packed {
        logic [22:0] days;
        logic [16:0] sod;
    } d_t;

    typedef struct packed {
        logic [18:0] days_lo;
        logic [5:0]  q400_0;
        logic [3:0]  wx_lo;
        logic [3:0]  wq0_lo;
        logic [12:0] sod_lo;
        logic [4:0]  hq0;
    } e_t;

    typedef struct packed {
        logic [5:0]  q400_0;
        logic [18:0] d1_r0;
        logic [3:0]  w_r0;
        logic [4:0]  hq0;
        logic [12:0] h_r0;
    } f_t;

    typedef struct packed {
        logic [5:0]  q400;
        logic [17:0] d1;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [11:0] rem_h;
    } g_t;

    typedef struct packed {
        logic [5:0]  q400;
        logic [1:0]  cent;
        logic [15:0] d2;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [6:0]  rem_lo7;
        logic [5:0]  mq0;
    } h_t;

    typedef struct packed {
        logic [5:0]  q400;
        logic [1:0]  cent;
        logic [11:0] d2_lo;
        logic [4:0]  q4_0;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  mq0;
        logic [6:0]  m_r0;
    } i_t;

    typedef struct packed {
        logic [5:0]  q400;
        logic [1:0]  cent;
        logic [4:0]  q4_0;
        logic [11:0] q4_r0;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } j_t;

    typedef struct packed {
        logic [5:0]  q400;
        logic [1:0]  cent;
        logic [4:0]  q4;
        logic [11:0] d3;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } k_t;

    typedef struct packed {
        logic [12:0] years;
        logic [8:0]  yday;
        logic        leap;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } l_t;

    typedef struct packed {
        logic [12:0] years;
        logic [8:0]  yday;
        logic        leap;
        month_sel_t  sel;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } m_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [12:0] years;
        logic [2:0]  wday;
        logic [8:0]  yday;
    } n_t;

    a_t a_reg, a_next;
    b_t b_reg, b_next;
    c_t c_reg, c_next;
    d_t d_reg, d_next;
    e_t e_reg, e_next;
    f_t f_reg, f_next;
    g_t g_reg, g_next;
    h_t h_reg, h_next;
    i_t i_reg, i_next;
    j_t j_reg, j_next;
    k_t k_reg, k_next;
    l_t l_reg, l_next;
    m_t m_reg, m_next;
    n_t n_reg, n_next;

    logic [NUM_STAGES-1:0]    valid_reg, valid_next;
    logic signed [ZONE_W-1:0] zone_reg;
    logic                     pipe_en;

    // whole pipeline moves together unless a finished result is held
    assign pipe_en   = !(valid_reg[STG_OUT] && out_stall);
    assign in_stall  = !pipe_en;
    assign out_valid = valid_reg[STG_OUT];
    assign cfg_ready = 1'b1;
    assign valid_next = {valid_reg[NUM_STAGES-2:0], in_valid};

    // zone offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zone_reg <= ZONE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            zone_reg <= cfg_data;
        end
    end

    // stage A: rebase to 1601 and apply the zone offset
    always_comb
    begin
        a_next.s = {1'b0, unix_seconds} + EPOCH_BIAS
                 + {{(39 - ZONE_W){zone_reg[ZONE_W-1]}}, zone_reg};
    end

    // stage B: day count estimate, seconds / 128 times reciprocal of 675
    logic [54:0] b_prod;
    assign b_prod = 55'(a_reg.s[38:DAY_SHIFT]) * 55'(RCP_SEC);

    always_comb
    begin
        b_next.q0   = b_prod[54:32];
        b_next.t_lo = a_reg.s[17:DAY_SHIFT];
        b_next.lo7  = a_reg.s[DAY_SHIFT-1:0];
    end

    // stage C: remainder of the estimate, low bits suffice since it is below 2 * 675
    logic [10:0] c_mul;
    assign c_mul = 11'(b_reg.q0) * 11'(DAY_DIV);

    always_comb
    begin
        c_next.q0  = b_reg.q0;
        c_next.r0  = b_reg.t_lo - c_mul;
        c_next.lo7 = b_reg.lo7;
    end

    // stage D: correct day count, rebuild second of day
    logic        d_fix;
    logic [10:0] d_rem;
    assign d_fix = c_reg.r0 >= 11'(DAY_DIV);
    assign d_rem = d_fix ? (c_reg.r0 - 11'(DAY_DIV)) : c_reg.r0;

    always_comb
    begin
        d_next.days = c_reg.q0 + 23'(d_fix);
        d_next.sod  = {d_rem[9:0], c_reg.lo7};
    end

    // stage E: estimates for 400-year count, weekday and hour
    logic [28:0] e_q400_prod;
    logic [23:0] e_wx;
    logic [43:0] e_w_prod;
    logic [21:0] e_h_prod;
    assign e_q400_prod = 29'(d_reg.days) * 29'(RCP_400Y);
    assign e_wx        = 24'(d_reg.days) + 24'd1;
    assign e_w_prod    = 44'(e_wx) * 44'(RCP_WEEK);
    assign e_h_prod    = 22'(d_reg.sod) * 22'(RCP_HOUR);

    always_comb
    begin
        e_next.days_lo = d_reg.days[18:0];
        e_next.q400_0  = e_q400_prod[28:23];
        e_next.wx_lo   = e_wx[3:0];
        e_next.wq0_lo  = e_w_prod[27:24];
        e_next.sod_lo  = d_reg.sod[12:0];
        e_next.hq0     = e_h_prod[21:17];
    end

    // stage F: remainders of those estimates
    logic [18:0] f_d_mul;
    logic [3:0]  f_w_mul;
    logic [12:0] f_h_mul;
    assign f_d_mul = 19'(e_reg.q400_0) * 19'(DAYS_400Y);
    assign f_w_mul = e_reg.wq0_lo * 4'(WEEK_DAYS);
    assign f_h_mul = 13'(e_reg.hq0) * 13'(SEC_HOUR);

    always_comb
    begin
        f_next.q400_0 = e_reg.q400_0;
        f_next.d1_r0  = e_reg.days_lo - f_d_mul;
        f_next.w_r0   = e_reg.wx_lo - f_w_mul;
        f_next.hq0    = e_reg.hq0;
        f_next.h_r0   = e_reg.sod_lo - f_h_mul;
    end

    // stage G: one correction step each
    logic g_d_fix;
    logic g_h_fix;
    assign g_d_fix = f_reg.d1_r0 >= 19'(DAYS_400Y);
    assign g_h_fix = f_reg.h_r0 >= 13'(SEC_HOUR);

    always_comb
    begin
        g_next.q400  = f_reg.q400_0 + 6'(g_d_fix);
        g_next.d1    = g_d_fix ? 18'(f_reg.d1_r0 - 19'(DAYS_400Y)) : 18'(f_reg.d1_r0);
        g_next.wday  = (f_reg.w_r0 >= 4'(WEEK_DAYS)) ? 3'(f_reg.w_r0 - 4'(WEEK_DAYS))
                                                     : 3'(f_reg.w_r0);
        g_next.hour  = f_reg.hq0 + 5'(g_h_fix);
        g_next.rem_h = g_h_fix ? 12'(f_reg.h_r0 - 13'(SEC_HOUR)) : 12'(f_reg.h_r0);
    end

    // stage H: century by compare (last day of a 400-year span stays in century 3),
    // minute estimate
    logic [1:0]  h_cent;
    logic [17:0] h_sub;
    logic [17:0] h_m_prod;

    always_comb
    begin
        priority if (g_reg.d1 >= 18'(3 * DAYS_100Y))
            h_cent = 2'(CENT_MAX);
        else if (g_reg.d1 >= 18'(2 * DAYS_100Y))
            h_cent = 2'd2;
        else if (g_reg.d1 >= 18'(DAYS_100Y))
            h_cent = 2'd1;
        else
            h_cent = 2'd0;
    end

    assign h_sub    = 18'(h_cent) * 18'(DAYS_100Y);
    assign h_m_prod = 18'(g_reg.rem_h) * 18'(RCP_MIN);

    always_comb
    begin
        h_next.q400    = g_reg.q400;
        h_next.cent    = h_cent;
        h_next.d2      = 16'(g_reg.d1 - h_sub);
        h_next.wday    = g_reg.wday;
        h_next.hour    = g_reg.hour;
        h_next.rem_lo7 = g_reg.rem_h[6:0];
        h_next.mq0     = h_m_prod[17:12];
    end

    // stage I: 4-year estimate, minute remainder
    logic [20:0] i_q4_prod;
    logic [6:0]  i_m_mul;
    assign i_q4_prod = 21'(h_reg.d2) * 21'(RCP_4Y);
    assign i_m_mul   = 7'(h_reg.mq0) * 7'(SEC_MIN);

    always_comb
    begin
        i_next.q400  = h_reg.q400;
        i_next.cent  = h_reg.cent;
        i_next.d2_lo = h_reg.d2[11:0];
        i_next.q4_0  = i_q4_prod[20:16];
        i_next.wday  = h_reg.wday;
        i_next.hour  = h_reg.hour;
        i_next.mq0   = h_reg.mq0;
        i_next.m_r0  = h_reg.rem_lo7 - i_m_mul;
    end

    // stage J: 4-year remainder, minute and second final
    logic [11:0] j_q4_mul;
    logic        j_m_fix;
    assign j_q4_mul = 12'(i_reg.q4_0) * 12'(DAYS_4Y);
    assign j_m_fix  = i_reg.m_r0 >= 7'(SEC_MIN);

    always_comb
    begin
        j_next.q400   = i_reg.q400;
        j_next.cent   = i_reg.cent;
        j_next.q4_0   = i_reg.q4_0;
        j_next.q4_r0  = i_reg.d2_lo - j_q4_mul;
        j_next.wday   = i_reg.wday;
        j_next.hour   = i_reg.hour;
        j_next.minute = i_reg.mq0 + 6'(j_m_fix);
        j_next.second = j_m_fix ? 6'(i_reg.m_r0 - 7'(SEC_MIN)) : 6'(i_reg.m_r0);
    end

    // stage K: correct 4-year count and clamp it to the century
    logic        k_fix;
    logic [4:0]  k_q4;
    logic [11:0] k_rem;
    assign k_fix = j_reg.q4_r0 >= 12'(DAYS_4Y);
    assign k_q4  = j_reg.q4_0 + 5'(k_fix);
    assign k_rem = k_fix ? (j_reg.q4_r0 - 12'(DAYS_4Y)) : j_reg.q4_r0;

    always_comb
    begin
        k_next.q400   = j_reg.q400;
        k_next.cent   = j_reg.cent;
        k_next.wday   = j_reg.wday;
        k_next.hour   = j_reg.hour;
        k_next.minute = j_reg.minute;
        k_next.second = j_reg.second;
        if (k_q4 > 5'(QUAD_MAX))
        begin
            k_next.q4 = 5'(QUAD_MAX);
            k_next.d3 = k_rem + 12'(DAYS_4Y);
        end
        else
        begin
            k_next.q4 = k_q4;
            k_next.d3 = k_rem;
        end
    end

    // stage L: year in the 4-year span, year number, leap flag
    logic [1:0]  l_ann;
    logic [11:0] l_sub;
    logic [15:0] l_year;

    always_comb
    begin
        priority if (k_reg.d3 >= 12'(3 * DAYS_1Y))
            l_ann = 2'(ANN_MAX);
        else if (k_reg.d3 >= 12'(2 * DAYS_1Y))
            l_ann = 2'd2;
        else if (k_reg.d3 >= 12'(DAYS_1Y))
            l_ann = 2'd1;
        else
            l_ann = 2'd0;
    end

    assign l_sub  = 12'(l_ann) * 12'(DAYS_1Y);
    assign l_year = 16'(YEAR_BASE) + 16'(k_reg.q400) * 16'd400 + 16'(k_reg.cent) * 16'd100
                  + 16'(k_reg.q4) * 16'd4 + 16'(l_ann);

    always_comb
    begin
        l_next.years  = 13'(l_year - 16'(YEAR_TM));
        l_next.yday   = 9'(k_reg.d3 - l_sub);
        // divisible by 4 only in the fourth year; century years leap only at 400
        l_next.leap   = (l_ann == 2'(ANN_MAX))
                     && ((k_reg.q4 != 5'(QUAD_MAX)) || (k_reg.cent == 2'(CENT_MAX)));
        l_next.wday   = k_reg.wday;
        l_next.hour   = k_reg.hour;
        l_next.minute = k_reg.minute;
        l_next.second = k_reg.second;
    end

    // stage M: month search over the cumulative table
    always_comb
    begin
        m_next.years  = l_reg.years;
        m_next.yday   = l_reg.yday;
        m_next.leap   = l_reg.leap;
        m_next.sel    = month_find(l_reg.yday, l_reg.leap);
        m_next.wday   = l_reg.wday;
        m_next.hour   = l_reg.hour;
        m_next.minute = l_reg.minute;
        m_next.second = l_reg.second;
    end

    // stage N: day of month, output register
    logic [8:0] n_base;
    assign n_base = CUM_DAYS[m_reg.leap][m_reg.sel.mon];

    always_comb
    begin
        n_next.second = m_reg.second;
        n_next.minute = m_reg.minute;
        n_next.hour   = m_reg.hour;
        n_next.mday   = m_reg.sel.hit ? 5'(m_reg.yday - n_base + 9'd1) : 5'd1;
        n_next.month  = m_reg.sel.mon;
        n_next.years  = m_reg.years;
        n_next.wday   = m_reg.wday;
        n_next.yday   = m_reg.yday;
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (pipe_en)
        begin
            valid_reg <= valid_next;
        end
    end

    // stage payloads, no reset
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
            e_reg <= e_next;
            f_reg <= f_next;
            g_reg <= g_next;
            h_reg <= h_next;
            i_reg <= i_next;
            j_reg <= j_next;
            k_reg <= k_next;
            l_reg <= l_next;
            m_reg <= m_next;
            n_reg <= n_next;
        end
    end

    assign second_of_minute = n_reg.second;
    assign minute_of_hour   = n_reg.minute;
    assign hour_of_day      = n_reg.hour;
    assign day_of_month     = n_reg.mday;
    assign month_index      = n_reg.month;
    assign years_since_1900 = n_reg.years;
    assign day_of_week      = n_reg.wday;
    assign day_of_year      = n_reg.yday;

    // checks
    `ASSERT_NEXT(a_freeze, clk, rst_n, !pipe_en, $stable(valid_reg) && $stable(n_reg), "pipeline moved while output held")
    `ASSERT_NEXT(a_cfg_write, clk, rst_n, cfg_valid && cfg_ready, zone_reg == $past(cfg_data), "zone offset write lost")
    `ASSERT_IMPLY(a_day_split, clk, rst_n, valid_reg[STG_D], d_reg.sod < 17'(SEC_DAY), "second of day out of range after correction")
    `ASSERT_IMPLY(a_fold, clk, rst_n, valid_reg[STG_G], (g_reg.d1 < 18'(DAYS_400Y)) && (g_reg.rem_h < 12'(SEC_HOUR)) && (g_reg.wday < 3'(WEEK_DAYS)), "remainder correction incomplete")

endmodule
